FILE: sv/srs_pkg.sv
// Shared types, constants and helpers for the sequencing read statistics block.
// Depends on nothing; every other file in sv/ imports it.

package srs_pkg;

   // Sizing
   localparam int MAX_LEN     = 512;
   localparam int COUNT_WIDTH = 32;
   localparam int QUAL_BINS   = 128;
   localparam int BASE_CODES  = 5;

   localparam int QH_DEPTH = MAX_LEN * QUAL_BINS;
   localparam int BH_DEPTH = MAX_LEN * BASE_CODES;
   localparam int LH_DEPTH = MAX_LEN;

   localparam int QH_AW = $clog2(QH_DEPTH);
   localparam int BH_AW = $clog2(BH_DEPTH);
   localparam int LH_AW = $clog2(LH_DEPTH);
   localparam int LEN_W = $clog2(MAX_LEN + 1);

   // Port widths fixed by the interface
   localparam int CMD_W  = 2;
   localparam int CHAR_W = 8;
   localparam int QUAL_W = 7;
   localparam int ADDR_W = 16;
   localparam int OLEN_W = 10;
   localparam int BIN_W  = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QP_W        = $clog2(QUEUE_DEPTH);

   // Characters of interest
   localparam logic [CHAR_W-1:0] CH_UP_C = 8'h43;  // 'C'
   localparam logic [CHAR_W-1:0] CH_LO_C = 8'h63;  // 'c'
   localparam logic [CHAR_W-1:0] CH_UP_A = 8'h41;  // 'A'
   localparam logic [CHAR_W-1:0] CH_LO_A = 8'h61;  // 'a'
   localparam logic [CHAR_W-1:0] CH_UP_G = 8'h47;  // 'G'
   localparam logic [CHAR_W-1:0] CH_LO_G = 8'h67;  // 'g'
   localparam logic [CHAR_W-1:0] CH_UP_N = 8'h4E;  // 'N'
   localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;  // '.'

   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_BIN     = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH    = 2'd0,
      CMD_RD_QUAL = 2'd1,
      CMD_RD_BASE = 2'd2,
      CMD_RD_LEN  = 2'd3
   } cmd_type;

   // Which histogram feeds the readout
   typedef enum logic [1:0] {
      SEL_NONE = 2'd0,
      SEL_QUAL = 2'd1,
      SEL_BASE = 2'd2,
      SEL_LEN  = 2'd3
   } sel_type;

   // One classified operation, front end to back end
   typedef struct packed {
      logic             has_result;
      logic             kind;
      sel_type          sel;
      logic             in_range;
      logic             qh_inc;
      logic             bh_inc;
      logic             lh_inc;
      logic [QH_AW-1:0] qh_addr;
      logic [BH_AW-1:0] bh_addr;
      logic [LH_AW-1:0] lh_addr;
      logic [LEN_W-1:0] rd_len;
      logic [LEN_W-1:0] rd_gc;
      logic             rd_over;
   } op_type;

   // Back end status seen by the front end
   typedef struct packed {
      logic clearing;
   } stat_type;

   // Map a base character to its histogram code
   function automatic logic [2:0] base_code(input logic [CHAR_W-1:0] ch);
      logic [2:0] code;
      unique case (ch)
         CH_UP_C, CH_LO_C: code = 3'd1;
         CH_UP_A, CH_LO_A: code = 3'd2;
         CH_UP_G, CH_LO_G: code = 3'd3;
         CH_UP_N, CH_DOT:  code = 3'd4;
         default:          code = 3'd0;
      endcase
      return code;
   endfunction

endpackage

FILE: sv/srs_front.sv
// Front end: accepts transactions, tracks the read in progress and classifies
// each transaction into an operation for the queue. Depends on srs_pkg.

module srs_front import srs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [CHAR_W-1:0] req_base_char,
   input  logic [QUAL_W-1:0] req_quality_char,
   input  logic              req_last_base,
   input  logic [ADDR_W-1:0] req_bin_address,
   input  stat_type          stat,
   input  logic              q_full,
   output logic              q_push,
   output op_type            q_op
);

   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] gc_ff, gc_in;
   logic             over_ff, over_in;

   logic             counted;
   logic             is_gc;
   logic [LEN_W-1:0] pos_new;
   logic [LEN_W-1:0] gc_new;
   logic             over_new;
   logic             accept;
   cmd_type          cmd;

   assign req_ready = !q_full && !stat.clearing;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;
   assign cmd       = cmd_type'(req_command);

   // Running read state after this base
   assign counted  = pos_ff < LEN_W'(MAX_LEN);
   assign is_gc    = (req_base_char == CH_UP_G) || (req_base_char == CH_UP_C);
   assign pos_new  = counted ? pos_ff + LEN_W'(1) : pos_ff;
   assign gc_new   = gc_ff + LEN_W'(counted && is_gc);
   assign over_new = over_ff || !counted;

   // Classify the transaction
   always_comb begin
      q_op          = '0;
      q_op.sel      = SEL_NONE;
      unique case (cmd)
         CMD_PUSH: begin
            q_op.qh_inc  = counted;
            q_op.bh_inc  = counted;
            q_op.qh_addr = {pos_ff[LH_AW-1:0], req_quality_char};
            q_op.bh_addr = BH_AW'({pos_ff, 2'b00}) + BH_AW'(pos_ff)
                         + BH_AW'(base_code(req_base_char));
            if (req_last_base) begin
               q_op.has_result = 1'b1;
               q_op.kind       = KIND_SUMMARY;
               q_op.lh_inc     = !over_new;
               q_op.lh_addr    = LH_AW'(pos_new - LEN_W'(1));
               q_op.rd_len     = pos_new;
               q_op.rd_gc      = gc_new;
               q_op.rd_over    = over_new;
            end
         end
         CMD_RD_QUAL: begin
            q_op.has_result = 1'b1;
            q_op.kind       = KIND_BIN;
            q_op.sel        = SEL_QUAL;
            q_op.in_range   = 32'(req_bin_address) < 32'(QH_DEPTH);
            q_op.qh_addr    = QH_AW'(req_bin_address);
         end
         CMD_RD_BASE: begin
            q_op.has_result = 1'b1;
            q_op.kind       = KIND_BIN;
            q_op.sel        = SEL_BASE;
            q_op.in_range   = 32'(req_bin_address) < 32'(BH_DEPTH);
            q_op.bh_addr    = BH_AW'(req_bin_address);
         end
         CMD_RD_LEN: begin
            q_op.has_result = 1'b1;
            q_op.kind       = KIND_BIN;
            q_op.sel        = SEL_LEN;
            q_op.in_range   = 32'(req_bin_address) < 32'(LH_DEPTH);
            q_op.lh_addr    = LH_AW'(req_bin_address);
         end
         default: ;
      endcase
   end

   // Advance read state on pushes; drop it at the end of a read
   always_comb begin
      pos_in  = pos_ff;
      gc_in   = gc_ff;
      over_in = over_ff;
      if (accept && cmd == CMD_PUSH) begin
         if (req_last_base) begin
            pos_in  = '0;
            gc_in   = '0;
            over_in = 1'b0;
         end else begin
            pos_in  = pos_new;
            gc_in   = gc_new;
            over_in = over_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         gc_ff   <= '0;
         over_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         gc_ff   <= gc_in;
         over_ff <= over_in;
      end
   end

endmodule

FILE: sv/srs_queue.sv
// Short queue of classified operations between front and back end.
// Depends on srs_pkg for op_type and the queue depth.

module srs_queue import srs_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   valid,
   output op_type pop_op
);

   op_type          entry_ff [QUEUE_DEPTH];
   logic [QP_W-1:0] wr_ptr_ff;
   logic [QP_W-1:0] rd_ptr_ff;
   logic [QP_W:0]   count_ff, count_in;

   assign full   = count_ff == (QP_W+1)'(QUEUE_DEPTH);
   assign valid  = count_ff != '0;
   assign pop_op = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + (QP_W+1)'(1);
      if (pop && !push) count_in = count_ff - (QP_W+1)'(1);
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_op;
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QP_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QP_W'(1);
         count_ff <= count_in;
      end
   end

endmodule

FILE: sv/srs_back.sv
// Back end: clears the histograms after reset, runs the read-modify-write of
// each operation on the three histogram memories and holds the result register.
// Depends on srs_pkg.

module srs_back import srs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  op_type            q_op,
   output logic              q_pop,
   output stat_type          stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_result_kind,
   output logic [OLEN_W-1:0] rsp_read_length,
   output logic [OLEN_W-1:0] rsp_gc_count,
   output logic              rsp_overlong,
   output logic [BIN_W-1:0]  rsp_bin_value
);

   // Histogram memories
   logic [COUNT_WIDTH-1:0] qh_mem_ff [QH_DEPTH];
   logic [COUNT_WIDTH-1:0] bh_mem_ff [BH_DEPTH];
   logic [COUNT_WIDTH-1:0] lh_mem_ff [LH_DEPTH];

   logic [COUNT_WIDTH-1:0] rd_q_ff, rd_b_ff, rd_l_ff;

   // Clearing pass
   logic             clr_active_ff, clr_active_in;
   logic [QH_AW-1:0] clr_cnt_ff;

   // Execute stage
   logic   s1_vld_ff, s1_vld_in;
   op_type s1_op_ff;
   logic   s1_go;
   logic   out_free;

   // Most recent write per memory, for forwarding
   logic                   lw_q_vld_ff, lw_b_vld_ff, lw_l_vld_ff;
   logic [QH_AW-1:0]       lw_q_addr_ff;
   logic [BH_AW-1:0]       lw_b_addr_ff;
   logic [LH_AW-1:0]       lw_l_addr_ff;
   logic [COUNT_WIDTH-1:0] lw_q_data_ff, lw_b_data_ff, lw_l_data_ff;

   logic [COUNT_WIDTH-1:0] fwd_q, fwd_b, fwd_l;
   logic [COUNT_WIDTH-1:0] inc_q, inc_b, inc_l;
   logic [COUNT_WIDTH-1:0] sel_val;

   logic                   qh_we, bh_we, lh_we;
   logic [QH_AW-1:0]       qh_wa;
   logic [BH_AW-1:0]       bh_wa;
   logic [LH_AW-1:0]       lh_wa;
   logic [COUNT_WIDTH-1:0] qh_wd, bh_wd, lh_wd;
   logic                   upd_q, upd_b, upd_l;

   // Output register
   logic              rsp_vld_ff, rsp_vld_in;
   logic              rsp_kind_ff;
   logic [OLEN_W-1:0] rsp_len_ff;
   logic [OLEN_W-1:0] rsp_gc_ff;
   logic              rsp_over_ff;
   logic [BIN_W-1:0]  rsp_bin_ff;

   assign stat.clearing = clr_active_ff;

   // Handshake between queue, execute stage and output register
   assign out_free = !rsp_vld_ff || rsp_ready;
   assign s1_go    = s1_vld_ff && (!s1_op_ff.has_result || out_free);
   assign q_pop    = q_valid && !clr_active_ff && (!s1_vld_ff || s1_go);
   assign s1_vld_in = q_pop ? 1'b1 : (s1_go ? 1'b0 : s1_vld_ff);

   // Forward the latest write over stale read data
   assign fwd_q = (lw_q_vld_ff && lw_q_addr_ff == s1_op_ff.qh_addr) ? lw_q_data_ff : rd_q_ff;
   assign fwd_b = (lw_b_vld_ff && lw_b_addr_ff == s1_op_ff.bh_addr) ? lw_b_data_ff : rd_b_ff;
   assign fwd_l = (lw_l_vld_ff && lw_l_addr_ff == s1_op_ff.lh_addr) ? lw_l_data_ff : rd_l_ff;

   assign inc_q = fwd_q + COUNT_WIDTH'(1);
   assign inc_b = fwd_b + COUNT_WIDTH'(1);
   assign inc_l = fwd_l + COUNT_WIDTH'(1);

   assign upd_q = s1_go && s1_op_ff.qh_inc;
   assign upd_b = s1_go && s1_op_ff.bh_inc;
   assign upd_l = s1_go && s1_op_ff.lh_inc;

   // Write ports: zero sweep while clearing, else increment
   always_comb begin
      qh_we = upd_q;
      bh_we = upd_b;
      lh_we = upd_l;
      qh_wa = s1_op_ff.qh_addr;
      bh_wa = s1_op_ff.bh_addr;
      lh_wa = s1_op_ff.lh_addr;
      qh_wd = inc_q;
      bh_wd = inc_b;
      lh_wd = inc_l;
      if (clr_active_ff) begin
         qh_we = 1'b1;
         bh_we = 32'(clr_cnt_ff) < 32'(BH_DEPTH);
         lh_we = 32'(clr_cnt_ff) < 32'(LH_DEPTH);
         qh_wa = clr_cnt_ff;
         bh_wa = BH_AW'(clr_cnt_ff);
         lh_wa = LH_AW'(clr_cnt_ff);
         qh_wd = '0;
         bh_wd = '0;
         lh_wd = '0;
      end
   end

   // Memories: registered read on pop, one write a cycle
   always_ff @(posedge clock) begin
      if (q_pop) rd_q_ff <= qh_mem_ff[q_op.qh_addr];
      if (qh_we) qh_mem_ff[qh_wa] <= qh_wd;
   end

   always_ff @(posedge clock) begin
      if (q_pop) rd_b_ff <= bh_mem_ff[q_op.bh_addr];
      if (bh_we) bh_mem_ff[bh_wa] <= bh_wd;
   end

   always_ff @(posedge clock) begin
      if (q_pop) rd_l_ff <= lh_mem_ff[q_op.lh_addr];
      if (lh_we) lh_mem_ff[lh_wa] <= lh_wd;
   end

   // Pick the readout value
   always_comb begin
      unique case (s1_op_ff.sel)
         SEL_QUAL: sel_val = fwd_q;
         SEL_BASE: sel_val = fwd_b;
         SEL_LEN:  sel_val = fwd_l;
         SEL_NONE: sel_val = '0;
         default:  sel_val = '0;
      endcase
   end

   assign clr_active_in = clr_active_ff && (clr_cnt_ff != QH_AW'(QH_DEPTH - 1));
   assign rsp_vld_in    = (s1_go && s1_op_ff.has_result) ? 1'b1
                        : (rsp_ready ? 1'b0 : rsp_vld_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         s1_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         lw_q_vld_ff   <= 1'b0;
         lw_b_vld_ff   <= 1'b0;
         lw_l_vld_ff   <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         if (clr_active_ff) clr_cnt_ff <= clr_cnt_ff + QH_AW'(1);
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (upd_q) lw_q_vld_ff <= 1'b1;
         if (upd_b) lw_b_vld_ff <= 1'b1;
         if (upd_l) lw_l_vld_ff <= 1'b1;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (q_pop) s1_op_ff <= q_op;
      if (upd_q) begin
         lw_q_addr_ff <= s1_op_ff.qh_addr;
         lw_q_data_ff <= inc_q;
      end
      if (upd_b) begin
         lw_b_addr_ff <= s1_op_ff.bh_addr;
         lw_b_data_ff <= inc_b;
      end
      if (upd_l) begin
         lw_l_addr_ff <= s1_op_ff.lh_addr;
         lw_l_data_ff <= inc_l;
      end
      if (s1_go && s1_op_ff.has_result) begin
         rsp_kind_ff <= s1_op_ff.kind;
         rsp_len_ff  <= OLEN_W'(s1_op_ff.rd_len);
         rsp_gc_ff   <= OLEN_W'(s1_op_ff.rd_gc);
         rsp_over_ff <= s1_op_ff.rd_over;
         rsp_bin_ff  <= s1_op_ff.in_range ? BIN_W'(sel_val) : '0;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_read_length = rsp_len_ff;
   assign rsp_gc_count    = rsp_gc_ff;
   assign rsp_overlong    = rsp_over_ff;
   assign rsp_bin_value   = rsp_bin_ff;

endmodule

FILE: sv/sequencing_read_statistics_top.sv
// Top level of the sequencing read statistics block: front end, operation
// queue and histogram back end. Depends on srs_pkg, srs_front, srs_queue, srs_back.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  command, base_char, quality_char,
//                                            last_base, bin_address
//   rsp_     out        rsp_valid/rsp_ready  result_kind, read_length, gc_count,
//                                            overlong, bin_value
//
// One transaction per cycle is sustained unless the result register stalls or the
// clearing sweep runs; each memory has one read and one write port; the increment
// is computed from the registered read data in the execute stage. A result passes
// through the queue entry, the execute stage and the result register. After reset
// the histograms are swept to zero over all QH_DEPTH addresses (65536 at MAX_LEN
// 512), during which req_ready stays low. A stalled result register holds an execute
// stage op that has a result; the four-entry queue keeps accepting until it fills.

module sequencing_read_statistics_top import srs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [CHAR_W-1:0] req_base_char,
   input  logic [QUAL_W-1:0] req_quality_char,
   input  logic              req_last_base,
   input  logic [ADDR_W-1:0] req_bin_address,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_result_kind,
   output logic [OLEN_W-1:0] rsp_read_length,
   output logic [OLEN_W-1:0] rsp_gc_count,
   output logic              rsp_overlong,
   output logic [BIN_W-1:0]  rsp_bin_value
);

   stat_type stat;
   logic     q_full;
   logic     q_push;
   op_type   q_push_op;
   logic     q_pop;
   logic     q_valid;
   op_type   q_pop_op;

   srs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_base_char    (req_base_char),
      .req_quality_char (req_quality_char),
      .req_last_base    (req_last_base),
      .req_bin_address  (req_bin_address),
      .stat             (stat),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_op             (q_push_op)
   );

   srs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_push_op),
      .full    (q_full),
      .pop     (q_pop),
      .valid   (q_valid),
      .pop_op  (q_pop_op)
   );

   srs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_op            (q_pop_op),
      .q_pop           (q_pop),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_read_length (rsp_read_length),
      .rsp_gc_count    (rsp_gc_count),
      .rsp_overlong    (rsp_overlong),
      .rsp_bin_value   (rsp_bin_value)
   );

endmodule

FILE: dv/sequencing_read_statistics_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sequencing_read_statistics_top: a local model of the
// read statistics predicts every summary and bin readout. Depends on srs_pkg and sv/.

module sequencing_read_statistics_top_tb;
   import srs_pkg::*;

   // Base codes of the per-position base histogram
   localparam logic [2:0] CODE_T = 3'd0;
   localparam logic [2:0] CODE_C = 3'd1;
   localparam logic [2:0] CODE_A = 3'd2;
   localparam logic [2:0] CODE_G = 3'd3;
   localparam logic [2:0] CODE_N = 3'd4;

   typedef struct {
      logic              kind;
      logic [OLEN_W-1:0] read_len;
      logic [OLEN_W-1:0] gc;
      logic              over;
      logic [BIN_W-1:0]  value;
   } read_result_type;

   logic              clock;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic [CMD_W-1:0]  req_command      = CMD_PUSH;
   logic [CHAR_W-1:0] req_base_char    = '0;
   logic [QUAL_W-1:0] req_quality_char = '0;
   logic              req_last_base    = 1'b0;
   logic [ADDR_W-1:0] req_bin_address  = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic              rsp_result_kind;
   logic [OLEN_W-1:0] rsp_read_length;
   logic [OLEN_W-1:0] rsp_gc_count;
   logic              rsp_overlong;
   logic [BIN_W-1:0]  rsp_bin_value;

   // Model copy of the histograms and the read in progress
   bit [BIN_W-1:0] qual_hist [QH_DEPTH];
   bit [BIN_W-1:0] base_hist [BH_DEPTH];
   bit [BIN_W-1:0] len_hist  [LH_DEPTH];
   int unsigned    cur_pos  = 0;
   int unsigned    cur_gc   = 0;
   bit             cur_over = 1'b0;

   read_result_type expected_results[$];
   int              errors      = 0;
   int              items_sent  = 0;
   bit              idle_on     = 1'b1;
   int              hold_cycles = 0;

   sequencing_read_statistics_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_base_char    (req_base_char),
      .req_quality_char (req_quality_char),
      .req_last_base    (req_last_base),
      .req_bin_address  (req_bin_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_read_length  (rsp_read_length),
      .rsp_gc_count     (rsp_gc_count),
      .rsp_overlong     (rsp_overlong),
      .rsp_bin_value    (rsp_bin_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("sequencing_read_statistics_top_tb: done, errors");
      $finish;
   end

   function automatic logic [2:0] char_code(logic [CHAR_W-1:0] ch);
      case (ch)
         "C", "c": return CODE_C;
         "A", "a": return CODE_A;
         "G", "g": return CODE_G;
         "N", ".": return CODE_N;
         default:  return CODE_T;
      endcase
   endfunction

   // Update the model with one accepted transaction; queue its result, if any
   function automatic void predict_stats(cmd_type cmd, logic [CHAR_W-1:0] bch,
                                         logic [QUAL_W-1:0] qch, logic last,
                                         logic [ADDR_W-1:0] addr);
      read_result_type r;
      r = '{kind: KIND_BIN, read_len: '0, gc: '0, over: 1'b0, value: '0};
      case (cmd)
         CMD_RD_QUAL: r.value = (addr < QH_DEPTH) ? qual_hist[addr] : '0;
         CMD_RD_BASE: r.value = (addr < BH_DEPTH) ? base_hist[addr] : '0;
         CMD_RD_LEN:  r.value = (addr < LH_DEPTH) ? len_hist[addr] : '0;
         default: begin
            // count the base unless the read is already past its last position
            if (cur_pos < MAX_LEN) begin
               qual_hist[cur_pos * QUAL_BINS + qch]++;
               base_hist[cur_pos * BASE_CODES + char_code(bch)]++;
               if (bch == "G" || bch == "C")
                  cur_gc++;
               cur_pos++;
            end else begin
               cur_over = 1'b1;
            end
            if (!last)
               return;
            if (!cur_over)
               len_hist[cur_pos - 1]++;
            r.kind     = KIND_SUMMARY;
            r.read_len = OLEN_W'(cur_pos);
            r.gc       = OLEN_W'(cur_gc);
            r.over     = cur_over;
            cur_pos    = 0;
            cur_gc     = 0;
            cur_over   = 1'b0;
         end
      endcase
      expected_results.push_back(r);
   endfunction

   function automatic logic [CHAR_W-1:0] rand_char();
      logic [CHAR_W-1:0] common [4] = '{"A", "C", "G", "T"};
      logic [CHAR_W-1:0] rare [9]   = '{"a", "c", "g", "t", "u", "U", "n", "N", "."};
      case ($urandom_range(0, 9))
         0:       return rare[$urandom_range(0, 8)];
         1:       return CHAR_W'($urandom_range(0, 255));
         default: return common[$urandom_range(0, 3)];
      endcase
   endfunction

   // Mostly the usual Phred+33 range, sometimes any code
   function automatic logic [QUAL_W-1:0] rand_qual();
      if ($urandom_range(0, 6) == 0)
         return QUAL_W'($urandom_range(0, 127));
      return QUAL_W'($urandom_range(33, 74));
   endfunction

   // Offer one transaction, hold it until accepted, then predict it
   task automatic send_item(cmd_type cmd, logic [CHAR_W-1:0] bch, logic [QUAL_W-1:0] qch,
                            logic last, logic [ADDR_W-1:0] addr);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_base_char    <= bch;
      req_quality_char <= qch;
      req_last_base    <= last;
      req_bin_address  <= addr;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_stats(cmd, bch, qch, last, addr);
      items_sent++;
   endtask

   task automatic send_random_readout();
      cmd_type           cmd;
      logic [ADDR_W-1:0] addr;
      cmd = cmd_type'($urandom_range(CMD_RD_QUAL, CMD_RD_LEN));
      if ($urandom_range(0, 4) == 0) begin
         addr = ADDR_W'($urandom_range(0, 65535));
      end else begin
         // aim at bins that short reads actually fill
         case (cmd)
            CMD_RD_QUAL: addr = ADDR_W'($urandom_range(0, 40) * QUAL_BINS + rand_qual());
            CMD_RD_BASE: addr = ADDR_W'($urandom_range(0, 120) * BASE_CODES
                                        + $urandom_range(CODE_T, CODE_N));
            default:     addr = ADDR_W'($urandom_range(0, 120));
         endcase
      end
      send_item(cmd, rand_char(), rand_qual(), 1'($urandom_range(0, 1)), addr);
   endtask

   // Push a whole read, with readouts now and then in the middle of it
   task automatic send_random_read(int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_random_readout();
         send_item(CMD_PUSH, rand_char(), rand_qual(), i == len - 1, ADDR_W'($urandom));
      end
   endtask

   // Histograms start cleared; addresses past a histogram read as zero
   task automatic test_empty_bins();
      send_item(CMD_RD_QUAL, 8'h00, '0, 1'b0, '0);
      send_item(CMD_RD_QUAL, 8'hFF, '1, 1'b1, '1);
      send_item(CMD_RD_BASE, 8'h00, '0, 1'b0, '0);
      send_item(CMD_RD_BASE, 8'hFF, '1, 1'b1, ADDR_W'(BH_DEPTH));
      send_item(CMD_RD_BASE, 8'h00, '0, 1'b0, '1);
      send_item(CMD_RD_LEN,  8'hFF, '1, 1'b1, '0);
      send_item(CMD_RD_LEN,  8'h00, '0, 1'b0, ADDR_W'(LH_DEPTH));
      send_item(CMD_RD_LEN,  8'hFF, '1, 1'b1, '1);
   endtask

   // Every character class, quality extremes, a readout inside a read, a one-base read
   task automatic test_base_codes();
      logic [CHAR_W-1:0] chars [15] = '{"T", "t", "U", "u", "C", "c", "A", "a",
                                        "G", "g", "N", ".", "n", 8'h00, 8'hFF};
      for (int i = 0; i < 15; i++) begin
         if (i == 3)
            send_item(CMD_RD_BASE, 8'hFF, '1, 1'b1, ADDR_W'(CODE_T));
         send_item(CMD_PUSH, chars[i], (i % 2) ? '1 : '0, i == 14, ADDR_W'($urandom));
      end
      send_item(CMD_PUSH, "G", 7'd40, 1'b1, '1);
      send_item(CMD_RD_QUAL, 8'h00, '0, 1'b0, ADDR_W'(QUAL_BINS + 127));
      send_item(CMD_RD_BASE, 8'h00, '0, 1'b0, ADDR_W'(11 * BASE_CODES + CODE_N));
      send_item(CMD_RD_LEN,  8'h00, '0, 1'b0, ADDR_W'(14));
      send_item(CMD_RD_LEN,  8'h00, '0, 1'b0, '0);
   endtask

   // A read of exactly MAX_LEN bases, then one that runs past it
   task automatic test_full_and_overlong_reads();
      logic [CHAR_W-1:0] ch;
      logic [QUAL_W-1:0] q;
      for (int i = 0; i < MAX_LEN; i++) begin
         ch = rand_char();
         q  = rand_qual();
         send_item(CMD_PUSH, ch, q, i == MAX_LEN - 1, ADDR_W'($urandom));
      end
      send_item(CMD_RD_LEN,  ch, q, 1'b0, ADDR_W'(MAX_LEN - 1));
      send_item(CMD_RD_QUAL, ch, q, 1'b0, ADDR_W'((MAX_LEN - 1) * QUAL_BINS + q));
      send_item(CMD_RD_BASE, ch, q, 1'b0,
                ADDR_W'((MAX_LEN - 1) * BASE_CODES + char_code(ch)));
      // all G/C, so the GC count reaches its top value as well
      for (int i = 0; i < MAX_LEN + 3; i++)
         send_item(CMD_PUSH, (i % 2) ? "G" : "C", rand_qual(), i == MAX_LEN + 2, '0);
      send_item(CMD_RD_LEN, "G", '0, 1'b0, ADDR_W'(MAX_LEN - 1));
   endtask

   // Hold off the result side long enough for the block to fill and stall its input
   task automatic test_output_stall();
      idle_on     = 1'b0;
      hold_cycles = 300;
      for (int i = 0; i < 24; i++) begin
         if (i % 3 == 0)
            send_random_read(2);
         else
            send_random_readout();
      end
      idle_on = 1'b1;
   endtask

   task automatic test_random_reads(int n_items, bit with_idle);
      int stop_at;
      int len;
      stop_at = items_sent + n_items;
      idle_on = with_idle;
      while (items_sent < stop_at) begin
         if (with_idle && $urandom_range(0, 7) == 0)
            idle_on = !idle_on;
         if ($urandom_range(0, 4) == 0) begin
            send_random_readout();
         end else begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(21, 120)
                                              : $urandom_range(1, 20);
            send_random_read(len);
         end
      end
   endtask

   // Drive the result-side ready: long holds on request, random stalls otherwise
   initial begin : rsp_ready_drive
      int n;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            n           = hold_cycles;
            hold_cycles = 0;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
         end else begin
            n = 1;
            rsp_ready <= 1'b1;
         end
         repeat (n) @(posedge clock);
      end
   end

   function automatic void check_field(string name, logic [BIN_W-1:0] want,
                                       logic [BIN_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // Compare each accepted result transaction with the oldest expectation
   always @(posedge clock) begin : result_check
      read_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d bin %0d",
                     $time, rsp_result_kind, rsp_bin_value);
            errors++;
         end else begin
            want = expected_results.pop_front();
            check_field("result_kind", want.kind, rsp_result_kind);
            check_field("read_length", want.read_len, rsp_read_length);
            check_field("gc_count", want.gc, rsp_gc_count);
            check_field("overlong", want.over, rsp_overlong);
            check_field("bin_value", want.value, rsp_bin_value);
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_bins();
      test_base_codes();
      test_full_and_overlong_reads();
      test_output_stall();
      test_random_reads(110, 1'b1);
      test_random_reads(50, 1'b0);
      req_valid <= 1'b0;
      // drain, then leave room for any stray result
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("sequencing_read_statistics_top_tb: done, clean");
      else
         $display("sequencing_read_statistics_top_tb: done, errors");
      $finish;
   end

endmodule

FILE: filelist.f
sv/srs_pkg.sv
sv/srs_front.sv
sv/srs_queue.sv
sv/srs_back.sv
sv/sequencing_read_statistics_top.sv
dv/sequencing_read_statistics_top_tb.sv
